[sv/assert_macros.svh]
// Assertion macros shared by the note sampling sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define NSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define NSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/nss_pkg.sv]
// Shared types and constants of the note sampling sequencer
`timescale 1ns / 1ps

package nss_pkg;

    localparam int unsigned MAX_VOICES = 64;
    localparam int unsigned SLOT_W     = $clog2(MAX_VOICES);
    localparam int unsigned VP_W       = 7;
    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        PH_NOISE   = 3'd0,
        PH_BEFORE  = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_AFTER   = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_VELOCITY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_WINDOW     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_BEFORE     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN          = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE          = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_AFTER      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_COUNT      = 4'd7;

    localparam logic [COUNT_W-1:0] DEFAULT_WINDOW_FRAMES = 32'd48000;

    // Upper nibbles of the status bytes; the channel fills the low nibble
    localparam logic [3:0] MIDI_PROGRAM  = 4'hC;
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
    localparam logic [7:0] PROGRAM_NONE  = 8'hFF;

    typedef struct packed {
        logic [7:0] prog;
        logic [6:0] note;
        logic [6:0] velocity;
    } voice_t;

    typedef struct packed {
        logic [3:0]         midi_channel;
        logic [6:0]         release_velocity;
        logic [COUNT_W-1:0] noise_window_frames;
        logic [COUNT_W-1:0] pause_before_frames;
        logic [COUNT_W-1:0] sustain_frames;
        logic [COUNT_W-1:0] release_frames;
        logic [COUNT_W-1:0] pause_after_frames;
        logic [VP_W-1:0]    voice_count;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic                record;
        logic                take_done;
        logic                midi_valid;
        logic [7:0]          midi_status;
        logic [6:0]          midi_data1;
        logic [6:0]          midi_data2;
        logic [SAMPLE_W-1:0] noise_floor;
        logic [VP_W-1:0]     current_voice;
    } result_t;

endpackage

[sv/nss_cfg_regs.sv]
// Configuration register file of the note sampling sequencer
`timescale 1ns / 1ps

module nss_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]   cfg_data,
    output nss_pkg::cfg_t                    cfg
);

    nss_pkg::cfg_t cfg_reg;
    nss_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                nss_pkg::CFG_MIDI_CHANNEL:     cfg_next.midi_channel = cfg_data[3:0];
                nss_pkg::CFG_RELEASE_VELOCITY: cfg_next.release_velocity = cfg_data[6:0];
                nss_pkg::CFG_NOISE_WINDOW:     cfg_next.noise_window_frames = cfg_data;
                nss_pkg::CFG_PAUSE_BEFORE:     cfg_next.pause_before_frames = cfg_data;
                nss_pkg::CFG_SUSTAIN:          cfg_next.sustain_frames = cfg_data;
                nss_pkg::CFG_RELEASE:          cfg_next.release_frames = cfg_data;
                nss_pkg::CFG_PAUSE_AFTER:      cfg_next.pause_after_frames = cfg_data;
                nss_pkg::CFG_VOICE_COUNT:      cfg_next.voice_count = cfg_data[6:0];
                default: ; // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.midi_channel        <= '0;
            cfg_reg.release_velocity    <= '0;
            cfg_reg.noise_window_frames <= nss_pkg::DEFAULT_WINDOW_FRAMES;
            cfg_reg.pause_before_frames <= '0;
            cfg_reg.sustain_frames      <= nss_pkg::DEFAULT_WINDOW_FRAMES;
            cfg_reg.release_frames      <= nss_pkg::DEFAULT_WINDOW_FRAMES;
            cfg_reg.pause_after_frames  <= '0;
            cfg_reg.voice_count         <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/nss_voice_mem.sv]
// Voice table: one write port, two registered read ports
`timescale 1ns / 1ps

module nss_voice_mem (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [nss_pkg::SLOT_W-1:0]   waddr,
    input  nss_pkg::voice_t              wdata,
    input  logic                         re,
    input  logic [nss_pkg::SLOT_W-1:0]   raddr_a,
    input  logic [nss_pkg::SLOT_W-1:0]   raddr_b,
    output nss_pkg::voice_t              rdata_a,
    output nss_pkg::voice_t              rdata_b
);

    nss_pkg::voice_t mem [nss_pkg::MAX_VOICES];
    nss_pkg::voice_t rdata_a_reg;
    nss_pkg::voice_t rdata_b_reg;

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

endmodule

[sv/nss_sequencer.sv]
// Phase sequencer: noise floor tracking, frame counting and MIDI message selection
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nss_sequencer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  proc,
    input  logic                                  opcode,
    input  logic signed [nss_pkg::SAMPLE_W-1:0]   sample_a,
    input  logic signed [nss_pkg::SAMPLE_W-1:0]   sample_b,
    input  nss_pkg::cfg_t                         cfg,
    input  nss_pkg::voice_t                       voice_cur,
    input  nss_pkg::voice_t                       voice_nxt,
    output nss_pkg::result_t                      res,
    output logic [nss_pkg::VP_W-1:0]              vp_addr
);

    nss_pkg::phase_t                  phase_reg, phase_next;
    logic [nss_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [nss_pkg::SAMPLE_W-1:0]     peak_reg, peak_next;
    logic [nss_pkg::VP_W-1:0]         vp_reg, vp_next;

    logic                             frm;
    logic [nss_pkg::COUNT_W-1:0]      count_inc;
    logic [nss_pkg::COUNT_W-1:0]      phase_len;
    logic                             hit;
    logic [nss_pkg::SAMPLE_W-1:0]     abs_a, abs_b, peak_ab, peak_max;
    logic [nss_pkg::VP_W-1:0]         active, vp_inc;
    logic                             more_first, more_next;

    logic                             rec, take_done, mv;
    logic [3:0]                       mcode;
    logic [6:0]                       d1, d2;

    assign frm       = proc && (opcode == nss_pkg::OP_FRAME) && (phase_reg != nss_pkg::PH_DONE);
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    // Two's complement magnitude; the most negative sample maps to 2^23
    assign abs_a    = sample_a[nss_pkg::SAMPLE_W-1] ? (~sample_a + 1'b1) : sample_a;
    assign abs_b    = sample_b[nss_pkg::SAMPLE_W-1] ? (~sample_b + 1'b1) : sample_b;
    assign peak_ab  = (abs_a > abs_b) ? abs_a : abs_b;
    assign peak_max = (peak_ab > peak_reg) ? peak_ab : peak_reg;

    assign active     = (cfg.voice_count > nss_pkg::VP_W'(nss_pkg::MAX_VOICES)) ?
                        nss_pkg::VP_W'(nss_pkg::MAX_VOICES) : cfg.voice_count;
    assign vp_inc     = vp_reg + 1'b1;
    assign more_first = vp_reg < active;
    assign more_next  = vp_inc < active;

    always_comb begin
        unique case (phase_reg)
            nss_pkg::PH_NOISE:   phase_len = cfg.noise_window_frames;
            nss_pkg::PH_BEFORE:  phase_len = cfg.pause_before_frames;
            nss_pkg::PH_SUSTAIN: phase_len = cfg.sustain_frames;
            nss_pkg::PH_RELEASE: phase_len = cfg.release_frames;
            nss_pkg::PH_AFTER:   phase_len = cfg.pause_after_frames;
            default:             phase_len = '0;
        endcase
    end

    assign hit = count_inc >= phase_len;

    // Next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        peak_next  = peak_reg;
        vp_next    = vp_reg;
        if (frm) begin
            count_next = count_inc;
            unique case (phase_reg)
                nss_pkg::PH_NOISE: begin
                    peak_next = peak_max;
                    if (hit) begin
                        count_next = '0;
                        phase_next = more_first ? nss_pkg::PH_BEFORE : nss_pkg::PH_DONE;
                    end
                end
                nss_pkg::PH_BEFORE: begin
                    if (hit) begin
                        count_next = '0;
                        phase_next = nss_pkg::PH_SUSTAIN;
                    end
                end
                nss_pkg::PH_SUSTAIN: begin
                    if (hit) begin
                        count_next = '0;
                        phase_next = nss_pkg::PH_RELEASE;
                    end
                end
                nss_pkg::PH_RELEASE: begin
                    if (hit) begin
                        count_next = '0;
                        phase_next = nss_pkg::PH_AFTER;
                    end
                end
                nss_pkg::PH_AFTER: begin
                    if (hit) begin
                        count_next = '0;
                        vp_next    = vp_inc;
                        phase_next = more_next ? nss_pkg::PH_BEFORE : nss_pkg::PH_DONE;
                    end
                end
                default: phase_next = nss_pkg::PH_DONE;
            endcase
        end
    end

    // Outputs
    always_comb begin
        rec       = 1'b0;
        take_done = 1'b0;
        mv        = 1'b0;
        mcode     = '0;
        d1        = '0;
        d2        = '0;
        if (frm) begin
            unique case (phase_reg)
                nss_pkg::PH_NOISE: begin
                    // Pointer is still zero here, so no previous program to compare
                    if (hit && more_first && (voice_cur.prog != nss_pkg::PROGRAM_NONE)) begin
                        mv    = 1'b1;
                        mcode = nss_pkg::MIDI_PROGRAM;
                        d1    = voice_cur.prog[6:0];
                    end
                end
                nss_pkg::PH_BEFORE: begin
                    if (hit) begin
                        mv    = 1'b1;
                        mcode = nss_pkg::MIDI_NOTE_ON;
                        d1    = voice_cur.note;
                        d2    = voice_cur.velocity;
                    end
                end
                nss_pkg::PH_SUSTAIN: begin
                    rec = 1'b1;
                    if (hit) begin
                        mv    = 1'b1;
                        mcode = nss_pkg::MIDI_NOTE_OFF;
                        d1    = voice_cur.note;
                        d2    = cfg.release_velocity;
                    end
                end
                nss_pkg::PH_RELEASE: begin
                    rec       = 1'b1;
                    take_done = hit;
                end
                nss_pkg::PH_AFTER: begin
                    // Skip the program change when the next voice keeps the same program
                    if (hit && more_next && (voice_nxt.prog != nss_pkg::PROGRAM_NONE) &&
                        (voice_nxt.prog != voice_cur.prog)) begin
                        mv    = 1'b1;
                        mcode = nss_pkg::MIDI_PROGRAM;
                        d1    = voice_nxt.prog[6:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= nss_pkg::PH_NOISE;
            count_reg <= '0;
            peak_reg  <= '0;
            vp_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
            vp_reg    <= vp_next;
        end
    end

    assign vp_addr = vp_next;

    assign res.phase         = phase_next;
    assign res.record        = rec;
    assign res.take_done     = take_done;
    assign res.midi_valid    = mv;
    assign res.midi_status   = mv ? {mcode, cfg.midi_channel} : 8'h00;
    assign res.midi_data1    = d1;
    assign res.midi_data2    = d2;
    assign res.noise_floor   = peak_next;
    assign res.current_voice = vp_next;

    `NSS_ASSERT_NOW(a_noise_at_first_voice, aclk, aresetn,
        phase_reg == nss_pkg::PH_NOISE, vp_reg == '0, "voice pointer moved during noise phase")
    `NSS_ASSERT_NOW(a_take_done_enters_after, aclk, aresetn,
        take_done, rec && (phase_next == nss_pkg::PH_AFTER), "take end without entering pause after")
    `NSS_ASSERT_NOW(a_midi_on_transition, aclk, aresetn,
        mv, frm && (count_next == '0) && (phase_next != phase_reg), "MIDI beat without a phase change")

endmodule

[sv/note_sampling_sequencer.sv]
// Top level of the note sampling sequencer: handshake, item and result registers
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A result appears on the m_ ports from the result register; the accepting edge loads
// the input register, and processing the held item loads the result register.
// Throughput: one item per cycle; the result register lets the next item enter while
// a result waits, and back-pressure passes from m_ready to s_ready in the same cycle.
// Reset (aresetn low, synchronous): phase noise, counters, peak and voice pointer
// cleared, config at defaults; voice table contents stay undefined until loaded.

module note_sampling_sequencer (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic signed [nss_pkg::SAMPLE_W-1:0]    s_sample_a,
    input  logic signed [nss_pkg::SAMPLE_W-1:0]    s_sample_b,
    input  logic [nss_pkg::SLOT_W-1:0]             s_entry_slot,
    input  logic [7:0]                             s_entry_program,
    input  logic [6:0]                             s_entry_note,
    input  logic [6:0]                             s_entry_velocity,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [2:0]                             m_phase,
    output logic                                   m_record,
    output logic                                   m_take_done,
    output logic                                   m_midi_valid,
    output logic [7:0]                             m_midi_status,
    output logic [6:0]                             m_midi_data1,
    output logic [6:0]                             m_midi_data2,
    output logic [nss_pkg::SAMPLE_W-1:0]           m_noise_floor,
    output logic [nss_pkg::VP_W-1:0]               m_current_voice,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nss_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [nss_pkg::CFG_DATA_W-1:0]         cfg_data
);

    nss_pkg::cfg_t                        cfg;
    nss_pkg::voice_t                      wr_voice;
    nss_pkg::voice_t                      voice_cur, voice_nxt;
    nss_pkg::result_t                     res;
    logic [nss_pkg::VP_W-1:0]             vp_addr;
    logic [nss_pkg::SLOT_W-1:0]           rd_cur_addr, rd_nxt_addr;

    logic                                 s_accept, advance, proc;

    logic                                 s1_valid_reg, s1_valid_next;
    logic                                 s1_opcode_reg;
    logic signed [nss_pkg::SAMPLE_W-1:0]  s1_sample_a_reg, s1_sample_b_reg;

    logic                                 m_valid_reg, m_valid_next;
    nss_pkg::result_t                     out_reg;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign proc     = s1_valid_reg && advance;

    assign wr_voice.prog     = s_entry_program;
    assign wr_voice.note     = s_entry_note;
    assign wr_voice.velocity = s_entry_velocity;

    // Read at the pointer the held item leaves behind, and the slot after it
    assign rd_cur_addr = vp_addr[nss_pkg::SLOT_W-1:0];
    assign rd_nxt_addr = rd_cur_addr + 1'b1;

    nss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nss_voice_mem u_mem (
        .aclk    (aclk),
        .we      (s_accept && (s_opcode == nss_pkg::OP_LOAD)),
        .waddr   (s_entry_slot),
        .wdata   (wr_voice),
        .re      (s_accept && (s_opcode == nss_pkg::OP_FRAME)),
        .raddr_a (rd_cur_addr),
        .raddr_b (rd_nxt_addr),
        .rdata_a (voice_cur),
        .rdata_b (voice_nxt)
    );

    nss_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .proc      (proc),
        .opcode    (s1_opcode_reg),
        .sample_a  (s1_sample_a_reg),
        .sample_b  (s1_sample_b_reg),
        .cfg       (cfg),
        .voice_cur (voice_cur),
        .voice_nxt (voice_nxt),
        .res       (res),
        .vp_addr   (vp_addr)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (proc) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Capture the beat; hold while the stage is stalled
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_opcode_reg   <= s_opcode;
            s1_sample_a_reg <= s_sample_a;
            s1_sample_b_reg <= s_sample_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_phase         = out_reg.phase;
    assign m_record        = out_reg.record;
    assign m_take_done     = out_reg.take_done;
    assign m_midi_valid    = out_reg.midi_valid;
    assign m_midi_status   = out_reg.midi_status;
    assign m_midi_data1    = out_reg.midi_data1;
    assign m_midi_data2    = out_reg.midi_data2;
    assign m_noise_floor   = out_reg.noise_floor;
    assign m_current_voice = out_reg.current_voice;

    `NSS_ASSERT_NEXT(a_proc_loads_result, aclk, aresetn,
        proc, m_valid_reg, "processed item left no result")
    `NSS_ASSERT_NEXT(a_stalled_item_kept, aclk, aresetn,
        s1_valid_reg && !advance, s1_valid_reg && $stable(s1_opcode_reg), "stalled item lost")

endmodule

[test/note_sampling_sequencer_tb.sv]
// Self-checking testbench of the note sampling sequencer: random beats, predictor, scoreboard
`timescale 1ns / 1ps

module note_sampling_sequencer_tb;
    import nss_pkg::*;

    localparam int SECTIONS        = 15;
    localparam int SECTION_BEATS   = 64;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int SETTLE_CYCLES   = 4;

    typedef struct {
        logic                op;
        logic [SAMPLE_W-1:0] sa;
        logic [SAMPLE_W-1:0] sb;
        logic [SLOT_W-1:0]   slot;
        logic [7:0]          prog;
        logic [6:0]          note;
        logic [6:0]          vel;
    } sequencer_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                       s_valid          = 1'b0;
    logic                       s_ready;
    logic                       s_opcode         = OP_LOAD;
    logic signed [SAMPLE_W-1:0] s_sample_a       = '0;
    logic signed [SAMPLE_W-1:0] s_sample_b       = '0;
    logic [SLOT_W-1:0]          s_entry_slot     = '0;
    logic [7:0]                 s_entry_program  = '0;
    logic [6:0]                 s_entry_note     = '0;
    logic [6:0]                 s_entry_velocity = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [2:0]          m_phase;
    logic                m_record;
    logic                m_take_done;
    logic                m_midi_valid;
    logic [7:0]          m_midi_status;
    logic [6:0]          m_midi_data1;
    logic [6:0]          m_midi_data2;
    logic [SAMPLE_W-1:0] m_noise_floor;
    logic [VP_W-1:0]     m_current_voice;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus side
    sequencer_beat_t pending_beats[$];
    sequencer_beat_t beat_on_bus;
    result_t         expected_results[$];
    int              beats_queued   = 0;
    int              beats_accepted = 0;
    int              tx_idle_pct    = 0;
    int              rx_idle_pct    = 0;
    logic            rx_hold_off    = 1'b0;
    bit              hold_off_armed = 1'b0;
    bit              slot_loaded [MAX_VOICES];
    logic [7:0]      queued_program [MAX_VOICES];

    // sequencer prediction state
    cfg_t               live_cfg;
    phase_t             phase_now;
    logic [COUNT_W-1:0] frames_in_phase;
    logic [SAMPLE_W-1:0] peak_level;
    int                 voice_ptr;
    voice_t             voice_store [MAX_VOICES];

    int mismatch_count     = 0;
    int results_checked    = 0;
    int midi_messages_seen = 0;
    int takes_seen         = 0;
    int cfg_writes         = 0;

    note_sampling_sequencer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_sample_a       (s_sample_a),
        .s_sample_b       (s_sample_b),
        .s_entry_slot     (s_entry_slot),
        .s_entry_program  (s_entry_program),
        .s_entry_note     (s_entry_note),
        .s_entry_velocity (s_entry_velocity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_phase          (m_phase),
        .m_record         (m_record),
        .m_take_done      (m_take_done),
        .m_midi_valid     (m_midi_valid),
        .m_midi_status    (m_midi_status),
        .m_midi_data1     (m_midi_data1),
        .m_midi_data2     (m_midi_data2),
        .m_noise_floor    (m_noise_floor),
        .m_current_voice  (m_current_voice),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int active_voices();
        return (live_cfg.voice_count > VP_W'(MAX_VOICES)) ? MAX_VOICES : int'(live_cfg.voice_count);
    endfunction

    function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw);
        return raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    endfunction

    function automatic void emit_message(input logic [3:0] kind, input logic [6:0] d1,
                                         input logic [6:0] d2, inout result_t res);
        res.midi_valid  = 1'b1;
        res.midi_status = {kind, live_cfg.midi_channel};
        res.midi_data1  = d1;
        res.midi_data2  = d2;
    endfunction

    function automatic void enter_phase(input phase_t next, inout result_t res);
        voice_t v;
        phase_now       = next;
        frames_in_phase = '0;
        if (next == PH_DONE || next == PH_AFTER) begin
            return;
        end
        v = voice_store[voice_ptr];
        case (next)
            PH_BEFORE: begin
                // skip the program change when it repeats the previous voice's program
                if (v.prog != PROGRAM_NONE &&
                    (voice_ptr == 0 || v.prog != voice_store[voice_ptr-1].prog))
                    emit_message(MIDI_PROGRAM, v.prog[6:0], 7'd0, res);
            end
            PH_SUSTAIN: emit_message(MIDI_NOTE_ON, v.note, v.velocity, res);
            PH_RELEASE: emit_message(MIDI_NOTE_OFF, v.note, live_cfg.release_velocity, res);
            default: ;
        endcase
    endfunction

    function automatic result_t predict_sequencer_step(input sequencer_beat_t b);
        result_t res;
        logic [SAMPLE_W-1:0] mag_a;
        logic [SAMPLE_W-1:0] mag_b;
        res = '0;
        if (b.op == OP_LOAD) begin
            voice_store[b.slot] = {b.prog, b.note, b.vel};
        end else if (phase_now != PH_DONE) begin
            if (frames_in_phase != '1)
                frames_in_phase++;
            case (phase_now)
                PH_NOISE: begin
                    mag_a = magnitude(b.sa);
                    mag_b = magnitude(b.sb);
                    if (mag_a > peak_level) peak_level = mag_a;
                    if (mag_b > peak_level) peak_level = mag_b;
                    if (frames_in_phase >= live_cfg.noise_window_frames)
                        enter_phase(voice_ptr < active_voices() ? PH_BEFORE : PH_DONE, res);
                end
                PH_BEFORE: begin
                    if (frames_in_phase >= live_cfg.pause_before_frames)
                        enter_phase(PH_SUSTAIN, res);
                end
                PH_SUSTAIN: begin
                    res.record = 1'b1;
                    if (frames_in_phase >= live_cfg.sustain_frames)
                        enter_phase(PH_RELEASE, res);
                end
                PH_RELEASE: begin
                    res.record = 1'b1;
                    if (frames_in_phase >= live_cfg.release_frames) begin
                        res.take_done = 1'b1;
                        enter_phase(PH_AFTER, res);
                    end
                end
                PH_AFTER: begin
                    if (frames_in_phase >= live_cfg.pause_after_frames) begin
                        voice_ptr++;
                        enter_phase(voice_ptr < active_voices() ? PH_BEFORE : PH_DONE, res);
                    end
                end
                default: ;
            endcase
        end
        res.phase         = phase_now;
        res.noise_floor   = peak_level;
        res.current_voice = VP_W'(voice_ptr);
        return res;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIDI_CHANNEL:     live_cfg.midi_channel        = data[3:0];
            CFG_RELEASE_VELOCITY: live_cfg.release_velocity    = data[6:0];
            CFG_NOISE_WINDOW:     live_cfg.noise_window_frames = data;
            CFG_PAUSE_BEFORE:     live_cfg.pause_before_frames = data;
            CFG_SUSTAIN:          live_cfg.sustain_frames      = data;
            CFG_RELEASE:          live_cfg.release_frames      = data;
            CFG_PAUSE_AFTER:      live_cfg.pause_after_frames  = data;
            CFG_VOICE_COUNT:      live_cfg.voice_count         = data[VP_W-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(),
                                        predict_sequencer_step(beat_on_bus));
                beats_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    beat_on_bus = pending_beats.pop_front();
                    s_opcode         <= beat_on_bus.op;
                    s_sample_a       <= beat_on_bus.sa;
                    s_sample_b       <= beat_on_bus.sb;
                    s_entry_slot     <= beat_on_bus.slot;
                    s_entry_program  <= beat_on_bus.prog;
                    s_entry_note     <= beat_on_bus.note;
                    s_entry_velocity <= beat_on_bus.vel;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= !rx_hold_off && ($urandom_range(99) >= rx_idle_pct);
    end

    // hold the result channel off long enough to back the block up into its input
    initial begin
        wait (hold_off_armed);
        @(posedge aclk);
        rx_hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        rx_hold_off <= 1'b0;
    end

    function automatic string describe(input result_t r);
        return $sformatf("phase=%0d rec=%0b done=%0b midi=%0b %02h %02h %02h floor=%06h voice=%0d",
                         r.phase, r.record, r.take_done, r.midi_valid, r.midi_status,
                         r.midi_data1, r.midi_data2, r.noise_floor, r.current_voice);
    endfunction

    function automatic void log_mismatch(input string why, input result_t want,
                                         input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s\n  expected %s\n  actual   %s", $realtime, why,
                     describe(want), describe(got));
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.phase         = phase_t'(m_phase);
            got.record        = m_record;
            got.take_done     = m_take_done;
            got.midi_valid    = m_midi_valid;
            got.midi_status   = m_midi_status;
            got.midi_data1    = m_midi_data1;
            got.midi_data2    = m_midi_data2;
            got.noise_floor   = m_noise_floor;
            got.current_voice = m_current_voice;
            midi_messages_seen += m_midi_valid;
            takes_seen         += m_take_done;
            if (expected_results.size() == 0) begin
                log_mismatch("result beat with nothing pending", '0, got);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.phase !== want.phase || got.record !== want.record ||
                    got.take_done !== want.take_done || got.midi_valid !== want.midi_valid ||
                    got.midi_status !== want.midi_status || got.midi_data1 !== want.midi_data1 ||
                    got.midi_data2 !== want.midi_data2 || got.noise_floor !== want.noise_floor ||
                    got.current_voice !== want.current_voice)
                    log_mismatch($sformatf("result %0d differs", results_checked), want, got);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic sequencer_beat_t random_beat(input logic op);
        sequencer_beat_t b;
        b.op   = op;
        b.sa   = SAMPLE_W'($urandom);
        b.sb   = SAMPLE_W'($urandom);
        b.slot = SLOT_W'($urandom);
        b.prog = 8'($urandom);
        b.note = 7'($urandom);
        b.vel  = 7'($urandom);
        return b;
    endfunction

    function automatic sequencer_beat_t frame_beat(input logic [SAMPLE_W-1:0] sa,
                                                   input logic [SAMPLE_W-1:0] sb);
        sequencer_beat_t b;
        b    = random_beat(OP_FRAME);
        b.sa = sa;
        b.sb = sb;
        return b;
    endfunction

    function automatic sequencer_beat_t load_beat(input int slot, input logic [7:0] prog,
                                                  input logic [6:0] note, input logic [6:0] vel);
        sequencer_beat_t b;
        b      = random_beat(OP_LOAD);
        b.slot = SLOT_W'(slot);
        b.prog = prog;
        b.note = note;
        b.vel  = vel;
        slot_loaded[slot]    = 1'b1;
        queued_program[slot] = prog;
        return b;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom_range(2000)) - SAMPLE_W'(1000);
            1: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < MAX_VOICES && slot_loaded[n])
            n++;
        return n;
    endfunction

    // grow the loaded prefix half the time, else rewrite a live slot or hit any slot
    function automatic sequencer_beat_t random_load();
        int         slot;
        int         prefix;
        logic [7:0] prog;
        prefix = loaded_prefix();
        if (prefix < MAX_VOICES && $urandom_range(1))
            slot = prefix;
        else if ($urandom_range(7) == 0 || prefix == 0)
            slot = $urandom_range(MAX_VOICES - 1);
        else
            slot = $urandom_range(prefix - 1);
        case ($urandom_range(9))
            0, 1:    prog = PROGRAM_NONE;
            2, 3, 4: prog = (slot > 0 && slot_loaded[slot-1]) ? queued_program[slot-1] :
                            8'($urandom);
            default: prog = 8'($urandom);
        endcase
        return load_beat(slot, prog, 7'($urandom), 7'($urandom));
    endfunction

    function automatic void queue_beat(input sequencer_beat_t b);
        pending_beats.insert(pending_beats.size(), b);
        beats_queued++;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 25)
            return $urandom_range(15, 6);
        return $urandom_range(4);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
        cfg_writes++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (beats_accepted != beats_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // park one length register at its maximum for a section, then pull it back
    task automatic retune_length(input logic [CFG_IDX_W-1:0] idx, input int park_section,
                                 input int s);
        if (s == park_section)
            write_reg(idx, '1);
        else if (s == park_section + 1 || $urandom_range(1))
            write_reg(idx, pick_length());
    endtask

    initial begin
        logic [7:0]          dir_prog  [8] = '{8'd5, 8'hFF, 8'd5, 8'd5, 8'd128, 8'd254, 8'd0, 8'd127};
        logic [6:0]          dir_note  [8] = '{7'd0, 7'd127, 7'd60, 7'd1, 7'd126, 7'd64, 7'd0, 7'd127};
        logic [6:0]          dir_vel   [8] = '{7'd127, 7'd0, 7'd1, 7'd126, 7'd64, 7'd100, 7'd0, 7'd127};
        logic [SAMPLE_W-1:0] dir_a     [6] = '{24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                                               24'h000064, 24'hFFFFFB};
        logic [SAMPLE_W-1:0] dir_b     [6] = '{24'h000000, 24'h000001, 24'h800001, 24'h000000,
                                               24'h800000, 24'h000007};
        int                  prefix;

        live_cfg                     = '0;
        live_cfg.noise_window_frames = DEFAULT_WINDOW_FRAMES;
        live_cfg.sustain_frames      = DEFAULT_WINDOW_FRAMES;
        live_cfg.release_frames      = DEFAULT_WINDOW_FRAMES;
        phase_now       = PH_NOISE;
        frames_in_phase = '0;
        peak_level      = '0;
        voice_ptr       = 0;
        tx_idle_pct     = 12;
        rx_idle_pct     = 71;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: every register, first voices with program and note extremes,
        // noise window held open while sample extremes go by
        write_reg(CFG_MIDI_CHANNEL, 32'd15);
        write_reg(CFG_RELEASE_VELOCITY, 32'd127);
        write_reg(CFG_NOISE_WINDOW, '1);
        write_reg(CFG_PAUSE_BEFORE, '0);
        write_reg(CFG_SUSTAIN, '0);
        write_reg(CFG_RELEASE, '0);
        write_reg(CFG_PAUSE_AFTER, '0);
        write_reg(CFG_VOICE_COUNT, 32'd8);
        for (int i = 0; i < 8; i++) begin
            queue_beat(load_beat(i, dir_prog[i], dir_note[i], dir_vel[i]));
            if (i < 6)
                queue_beat(frame_beat(dir_a[i], dir_b[i]));
        end
        wait_idle();

        // close the window at once and walk the first voices with one-frame phases
        write_reg(CFG_MIDI_CHANNEL, 32'd0);
        write_reg(CFG_RELEASE_VELOCITY, 32'd0);
        write_reg(CFG_NOISE_WINDOW, '0);
        for (int i = 0; i < 10; i++)
            queue_beat(frame_beat(pick_sample(), pick_sample()));
        wait_idle();

        for (int s = 0; s < SECTIONS; s++) begin
            if (s == 5) begin
                tx_idle_pct = 71;
                rx_idle_pct = 12;
            end else if (s == 10) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if ($urandom_range(1))
                write_reg(CFG_MIDI_CHANNEL, $urandom);
            if ($urandom_range(1))
                write_reg(CFG_RELEASE_VELOCITY, $urandom);
            if ($urandom_range(3) == 0)
                write_reg(CFG_NOISE_WINDOW, $urandom);
            retune_length(CFG_PAUSE_BEFORE, 1, s);
            retune_length(CFG_SUSTAIN, 2, s);
            retune_length(CFG_RELEASE, 3, s);
            retune_length(CFG_PAUSE_AFTER, 4, s);
            prefix = loaded_prefix();
            if (prefix == MAX_VOICES && $urandom_range(1))
                write_reg(CFG_VOICE_COUNT, $urandom_range(127, MAX_VOICES + 1));
            else
                write_reg(CFG_VOICE_COUNT, prefix);
            if (s == 3)
                hold_off_armed = 1'b1;
            for (int k = 0; k < SECTION_BEATS; k++) begin
                if ($urandom_range(99) < 18)
                    queue_beat(random_load());
                else
                    queue_beat(frame_beat(pick_sample(), pick_sample()));
            end
            wait_idle();
        end

        // fill the table, then run the remaining voices out to the finished phase
        for (int i = 0; i < MAX_VOICES; i++) begin
            if (!slot_loaded[i])
                queue_beat(load_beat(i, 8'($urandom), 7'($urandom), 7'($urandom)));
        end
        wait_idle();
        write_reg(CFG_PAUSE_BEFORE, '0);
        write_reg(CFG_SUSTAIN, '0);
        write_reg(CFG_RELEASE, '0);
        write_reg(CFG_PAUSE_AFTER, '0);
        write_reg(CFG_VOICE_COUNT, MAX_VOICES);
        repeat ((MAX_VOICES - voice_ptr) * 4 + 8)
            queue_beat(frame_beat(pick_sample(), pick_sample()));
        wait_idle();
        repeat (16) begin
            if ($urandom_range(1))
                queue_beat(random_load());
            else
                queue_beat(frame_beat(pick_sample(), pick_sample()));
        end
        wait_idle();

        $display("covered %0d beats and %0d register writes; %0d results checked",
                 beats_accepted, cfg_writes, results_checked);
        $display("%0d MIDI messages, %0d takes, last voice %0d, final phase %0d, noise floor %06h",
                 midi_messages_seen, takes_seen, voice_ptr, phase_now, peak_level);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, expected_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d of %0d beats accepted, %0d results pending",
                 beats_accepted, beats_queued, expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
